>>> rtl/mis_pkg.sv
`timescale 1ns / 1ps

package mis_pkg;

    localparam int CHANNELS  = 64;
    localparam int TIME_BITS = 48;

    // index width; one bit minimum so a single channel still has an address
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CMD_W    = 3;
    localparam int CHAN_W   = 6;
    localparam int STAMP_W  = 48;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;

    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_END     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ELAPSED = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUNNING     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEVER_USED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0]   count;
        logic [TIME_BITS-1:0] min_t;
        logic [TIME_BITS-1:0] max_t;
        logic [SUM_W-1:0]     sum;
    } t_stats;

endpackage

>>> rtl/multichannel_interval_stats.sv
`timescale 1ns / 1ps

// Channel  | Signals                                   | Handshake
// command  | i_cmd, i_channel, i_now_ticks             | taken when start && !busy
// result   | o_status, o_elapsed, o_interval_count,    | o_done high for one cycle
//          | o_min_interval, o_max_interval,           |
//          | o_total_time, o_is_running                |
//
// Each command runs in order: on acceptance the channel's entry is read from the
// stamp and statistics RAMs, S_DIFF forms the interval, and S_UPD updates flags,
// writes back and registers the result. o_done rises in the cycle after S_UPD,
// while busy is already low, so a new command may be taken then. busy is high
// in S_DIFF and S_UPD; the registered RAM read and the split of subtract from
// accumulate set these states. Reset (i_rst_n low at a clock edge)
// clears all channel flags and statistics valid bits at once, with no sweep.
// Results cannot be stalled by the receiver.

module multichannel_interval_stats (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mis_pkg::CMD_W-1:0]    i_cmd,
    input  logic [mis_pkg::CHAN_W-1:0]   i_channel,
    input  logic [mis_pkg::STAMP_W-1:0]  i_now_ticks,
    output logic                         o_done,
    output logic [mis_pkg::STATUS_W-1:0] o_status,
    output logic [mis_pkg::STAMP_W-1:0]  o_elapsed,
    output logic [mis_pkg::COUNT_W-1:0]  o_interval_count,
    output logic [mis_pkg::STAMP_W-1:0]  o_min_interval,
    output logic [mis_pkg::STAMP_W-1:0]  o_max_interval,
    output logic [mis_pkg::SUM_W-1:0]    o_total_time,
    output logic                         o_is_running
);
    import mis_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_UPD
    } t_state;

    t_state r_state;

    logic [TIME_BITS-1:0] stamp_mem [CHANNELS];
    t_stats               stats_mem [CHANNELS];

    logic [TIME_BITS-1:0] r_stamp_q;
    t_stats               r_stats_q;

    logic [CHANNELS-1:0] r_run;
    logic [CHANNELS-1:0] r_used;
    logic [CHANNELS-1:0] r_sval;

    logic [CMD_W-1:0]     r_cmd;
    logic [CHAN_W-1:0]    r_ch;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_elapsed;

    logic                 accept;
    logic [10:0]          ch_ext_in;
    logic [10:0]          ch_ext;
    logic [CH_W-1:0]      idx_in;
    logic [CH_W-1:0]      idx;
    logic [SUM_W-1:0]     now_ext;
    logic                 in_range;
    logic                 run_c;
    logic                 used_c;
    t_stats               cur;
    t_stats               upd;
    logic                 first;
    logic [SUM_W:0]       sum_add;
    logic                 stamp_we;
    logic                 stats_we;

    logic [STATUS_W-1:0]  n_status;
    logic [TIME_BITS-1:0] n_elapsed;
    t_stats               n_stats;
    logic                 n_running;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign ch_ext_in = 11'(i_channel);
    assign idx_in    = ch_ext_in[CH_W-1:0];
    assign ch_ext    = 11'(r_ch);
    assign idx       = ch_ext[CH_W-1:0];
    assign now_ext   = SUM_W'(i_now_ticks);
    assign in_range  = (ch_ext < 11'(CHANNELS));

    assign run_c  = r_run[idx];
    assign used_c = r_used[idx];
    assign cur    = r_sval[idx] ? r_stats_q : '0;

    // end-of-interval statistics update
    always_comb begin
        first       = (cur.count == '0);
        sum_add     = {1'b0, cur.sum} + (SUM_W + 1)'(r_elapsed);
        upd         = cur;
        upd.count   = (cur.count == '1) ? cur.count : cur.count + 1'b1;
        if (first || r_elapsed > cur.max_t) begin
            upd.max_t = r_elapsed;
        end
        if (first || r_elapsed < cur.min_t) begin
            upd.min_t = r_elapsed;
        end
        upd.sum = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end

    always_comb begin
        n_status  = ST_OK;
        n_elapsed = '0;
        n_stats   = '0;
        n_running = 1'b0;
        stamp_we  = 1'b0;
        stats_we  = 1'b0;
        if (r_cmd == CMD_START || r_cmd == CMD_END || r_cmd == CMD_ELAPSED
                || r_cmd == CMD_READ) begin
            if (!in_range) begin
                n_status = ST_NEVER_USED;
            end else begin
                n_stats   = cur;
                n_running = run_c;
                case (r_cmd)
                    CMD_START: begin
                        if (run_c) begin
                            n_status = ST_RUNNING;
                        end else begin
                            stamp_we = 1'b1;
                        end
                        n_running = 1'b1;
                    end
                    CMD_END, CMD_ELAPSED: begin
                        if (!used_c) begin
                            n_status = ST_NEVER_USED;
                        end else if (!run_c) begin
                            n_status = ST_NOT_RUNNING;
                        end else begin
                            n_elapsed = r_elapsed;
                            if (r_cmd == CMD_END) begin
                                stats_we  = 1'b1;
                                n_stats   = upd;
                                n_running = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (!used_c) begin
                            n_status = ST_NEVER_USED;
                        end
                    end
                endcase
            end
        end
    end

    // stamp and statistics RAMs: read on accept, write back in the update cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stamp_q <= stamp_mem[idx_in];
            r_stats_q <= stats_mem[idx_in];
        end
        if (r_state == S_UPD && stamp_we) begin
            stamp_mem[idx] <= r_now;
        end
        if (r_state == S_UPD && stats_we) begin
            stats_mem[idx] <= upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_run   <= '0;
            r_used  <= '0;
            r_sval  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_UPD);
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd;
                        r_ch    <= i_channel;
                        r_now   <= now_ext[TIME_BITS-1:0];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    // interval wraps modulo the timestamp width
                    r_elapsed <= r_now - r_stamp_q;
                    r_state   <= S_UPD;
                end
                S_UPD: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_run  <= '0;
                        r_used <= '0;
                        r_sval <= '0;
                    end
                    if (stamp_we) begin
                        r_run[idx]  <= 1'b1;
                        r_used[idx] <= 1'b1;
                    end
                    if (stats_we) begin
                        r_run[idx]  <= 1'b0;
                        r_sval[idx] <= 1'b1;
                    end
                    o_status         <= n_status;
                    o_elapsed        <= STAMP_W'(SUM_W'(n_elapsed));
                    o_interval_count <= n_stats.count;
                    o_min_interval   <= STAMP_W'(SUM_W'(n_stats.min_t));
                    o_max_interval   <= STAMP_W'(SUM_W'(n_stats.max_t));
                    o_total_time     <= n_stats.sum;
                    o_is_running     <= n_running;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
